/* sv/rbd_pkg.sv */
`default_nettype none

package rbd_pkg;

    // ring capacity, a power of two so ring indexes wrap by truncation
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [STATUS_W-1:0]      status_t;

    // command codes
    localparam cmd_t CMD_PUSH_BACK  = 3'd0;
    localparam cmd_t CMD_PUSH_FRONT = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_REMOVE_AT  = 3'd4;
    localparam cmd_t CMD_SEARCH     = 3'd5;
    localparam cmd_t CMD_CLEAR      = 3'd6;

    // status codes
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;
    localparam status_t STAT_RANGE = 2'd3;

    // ring store port control
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        logic rd_en;
        idx_t rd_addr;
    } ram_ctrl_t;

endpackage

`default_nettype wire

/* sv/rbd_ring_ram.sv */
`default_nettype none

module rbd_ring_ram (
    input  wire logic              aclk,
    input  wire rbd_pkg::ram_ctrl_t ctrl,
    input  wire rbd_pkg::word_t    wr_data,
    output rbd_pkg::word_t         rd_data
);
    import rbd_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ring_buffer_deque.sv */
// sequence: push, clear and rejected commands go idle, exec, finish; pops add a pop state;
// remove-at adds rm, then read/write per later entry; search adds read/compare per entry
// throughput: one word at a time; the next word is taken once the sequencer is
// back in idle, so a remove-at or search holds it for its whole ring store walk
// reset: synchronous active-low aresetn empties the deque (head and count zero);
// the ring store itself is not cleared and holds no valid bits
`default_nettype none

module ring_buffer_deque (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // command channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rbd_pkg::cmd_t     s_cmd,
    input  wire rbd_pkg::word_t    s_data_value,
    input  wire rbd_pkg::pos_t     s_position,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rbd_pkg::status_t       m_status,
    output rbd_pkg::word_t         m_result_value,
    output rbd_pkg::pos_t          m_found_position,
    output rbd_pkg::cnt_t          m_entry_count
);
    import rbd_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;  // waiting for a command word
    localparam logic [3:0] S_EXEC   = 4'd1;  // decode and first store access
    localparam logic [3:0] S_POP    = 4'd2;  // pop read data returns
    localparam logic [3:0] S_RM     = 4'd3;  // remove-at read data returns
    localparam logic [3:0] S_SH_RD  = 4'd4;  // shift loop: read next entry
    localparam logic [3:0] S_SH_WR  = 4'd5;  // shift loop: write it one place forward
    localparam logic [3:0] S_SR_RD  = 4'd6;  // search loop: read entry
    localparam logic [3:0] S_SR_CMP = 4'd7;  // search loop: compare entry
    localparam logic [3:0] S_FINISH = 4'd8;  // hand result to the output register

    logic [3:0] state_reg, state_next;

    // deque pointers
    idx_t head_reg, head_next;
    cnt_t count_reg, count_next;

    // latched command word
    cmd_t  cmd_reg, cmd_next;
    word_t value_reg, value_next;
    pos_t  pos_reg, pos_next;

    // walk index and per-command result
    idx_t    k_reg, k_next;
    status_t status_reg, status_next;
    word_t   word_reg, word_next;
    pos_t    found_reg, found_next;
    logic    hit_reg, hit_next;

    // output register
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    word_t   m_word_reg, m_word_next;
    pos_t    m_found_reg, m_found_next;
    cnt_t    m_count_reg, m_count_next;

    // ring store
    ram_ctrl_t ram_ctrl;
    word_t     ram_wr_data;
    word_t     ram_rd_data;

    // shared ring address unit: head plus a logical offset, wrapped
    idx_t ring_off;
    idx_t ring_addr;
    assign ring_addr = IDX_W'(head_reg + ring_off);

    // shared bound compare: is there an entry after position k
    logic k_more;
    assign k_more = (CNT_W'(k_reg) + CNT_W'(1)) < count_reg;

    logic is_full, no_entries, out_free, match;
    assign is_full    = count_reg == CNT_W'(DEPTH);
    assign no_entries = count_reg == '0;
    assign out_free   = !m_valid_reg || m_ready;
    assign match      = ram_rd_data == value_reg;

    rbd_ring_ram u_ram (
        .aclk    (aclk),
        .ctrl    (ram_ctrl),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    // logical offset of the entry the current state touches
    always_comb begin
        ring_off = k_reg;
        case (state_reg)
            S_EXEC: begin
                case (cmd_reg)
                    CMD_PUSH_BACK:  ring_off = IDX_W'(count_reg);
                    // one place before the current head
                    CMD_PUSH_FRONT: ring_off = '1;
                    CMD_POP_FRONT:  ring_off = '0;
                    CMD_POP_BACK:   ring_off = IDX_W'(count_reg - CNT_W'(1));
                    CMD_REMOVE_AT:  ring_off = IDX_W'(pos_reg);
                    default:        ring_off = k_reg;
                endcase
            end
            // new head after a front pop
            S_POP:   ring_off = IDX_W'(1);
            S_SH_RD: ring_off = k_reg + IDX_W'(1);
            default: ring_off = k_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        status_next  = status_reg;
        word_next    = word_reg;
        found_next   = found_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        m_status_next = m_status_reg;
        m_word_next  = m_word_reg;
        m_found_next = m_found_reg;
        m_count_next = m_count_reg;

        ram_ctrl.wr_en   = 1'b0;
        ram_ctrl.rd_en   = 1'b0;
        ram_ctrl.wr_addr = ring_addr;
        ram_ctrl.rd_addr = ring_addr;
        ram_wr_data      = value_reg;

        // result leaves when the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    value_next = s_data_value;
                    pos_next   = s_position;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = STAT_OK;
                word_next   = '0;
                found_next  = '0;
                hit_next    = 1'b0;
                k_next      = '0;
                state_next  = S_FINISH;
                case (cmd_reg)
                    CMD_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            ram_ctrl.wr_en = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            ram_ctrl.wr_en = 1'b1;
                            head_next      = ring_addr;
                            count_next     = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (no_entries) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            ram_ctrl.rd_en = 1'b1;
                            state_next     = S_POP;
                        end
                    end
                    CMD_REMOVE_AT: begin
                        if (no_entries) begin
                            status_next = STAT_EMPTY;
                        end else if (CNT_W'(pos_reg) >= count_reg) begin
                            status_next = STAT_RANGE;
                        end else begin
                            ram_ctrl.rd_en = 1'b1;
                            k_next         = IDX_W'(pos_reg);
                            state_next     = S_RM;
                        end
                    end
                    CMD_SEARCH: begin
                        if (no_entries) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            state_next = S_SR_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    default: begin
                        status_next = STAT_RANGE;
                    end
                endcase
            end
            S_POP: begin
                word_next  = ram_rd_data;
                count_next = count_reg - CNT_W'(1);
                if (cmd_reg == CMD_POP_FRONT) begin
                    head_next = ring_addr;
                end
                state_next = S_FINISH;
            end
            S_RM: begin
                word_next  = ram_rd_data;
                state_next = S_SH_RD;
            end
            S_SH_RD: begin
                if (k_more) begin
                    ram_ctrl.rd_en = 1'b1;
                    state_next     = S_SH_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
            end
            S_SH_WR: begin
                // close the gap: entry k+1 moves into place k
                ram_ctrl.wr_en = 1'b1;
                ram_wr_data    = ram_rd_data;
                k_next         = k_reg + IDX_W'(1);
                state_next     = S_SH_RD;
            end
            S_SR_RD: begin
                ram_ctrl.rd_en = 1'b1;
                state_next     = S_SR_CMP;
            end
            S_SR_CMP: begin
                // later matches overwrite earlier ones
                if (match) begin
                    hit_next   = 1'b1;
                    found_next = POS_W'(k_reg);
                end
                if (k_more) begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_SR_RD;
                end else begin
                    if (!(hit_reg || match)) begin
                        status_next = STAT_EMPTY;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_word_next   = word_reg;
                    m_found_next  = found_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        word_reg     <= word_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    // a new word is taken in idle even while a result still waits
    assign s_ready          = state_reg == S_IDLE;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_value   = m_word_reg;
    assign m_found_position = m_found_reg;
    assign m_entry_count    = m_count_reg;

endmodule

`default_nettype wire

/* tb/ring_buffer_deque_checker.sv */
`default_nettype none

module ring_buffer_deque_checker
    import rbd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_ready,
    input  wire cmd_t    s_cmd,
    input  wire word_t   s_data_value,
    input  wire pos_t    s_position,
    input  wire logic    m_valid,
    input  wire logic    m_ready,
    input  wire status_t m_status,
    input  wire word_t   m_result_value,
    input  wire pos_t    m_found_position,
    input  wire cnt_t    m_entry_count,
    output int           fail_count,
    output int           pending_words
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t status;
        word_t   value;
        pos_t    found;
        cnt_t    count;
    } deque_result_t;

    // shadow copy of the ring
    word_t ring_words [DEPTH];
    idx_t  head_ptr;
    int    live_count;

    deque_result_t expected_results [$];
    int            mismatch_count = 0;

    function automatic idx_t slot_of(input int logical);
        return idx_t'((int'(head_ptr) + logical) % DEPTH);
    endfunction

    // apply one command to the shadow ring, return what the block should answer
    function automatic deque_result_t deque_apply(input cmd_t c, input word_t v, input pos_t p);
        deque_result_t r;
        int            k;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        case (c)
            CMD_PUSH_BACK: begin
                if (live_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_words[slot_of(live_count)] = v;
                    live_count++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (live_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    head_ptr = idx_t'((int'(head_ptr) + DEPTH - 1) % DEPTH);
                    ring_words[head_ptr] = v;
                    live_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (live_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value  = ring_words[head_ptr];
                    head_ptr = slot_of(1);
                    live_count--;
                end
            end
            CMD_POP_BACK: begin
                if (live_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.value = ring_words[slot_of(live_count - 1)];
                    live_count--;
                end
            end
            CMD_REMOVE_AT: begin
                if (live_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (int'(p) >= live_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.value = ring_words[slot_of(int'(p))];
                    for (k = int'(p); k + 1 < live_count; k++)
                        ring_words[slot_of(k)] = ring_words[slot_of(k + 1)];
                    live_count--;
                end
            end
            CMD_SEARCH: begin
                if (live_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (k = 0; k < live_count; k++) begin
                        if (ring_words[slot_of(k)] == v) begin
                            hit     = 1'b1;
                            r.found = pos_t'(k);
                        end
                    end
                    if (!hit)
                        r.status = STAT_EMPTY;
                end
            end
            CMD_CLEAR: begin
                head_ptr   = '0;
                live_count = 0;
            end
            default: r.status = STAT_RANGE;
        endcase
        r.count = cnt_t'(live_count);
        return r;
    endfunction

    function automatic int field_miss(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        deque_result_t want;
        if (!aresetn) begin
            head_ptr   = '0;
            live_count = 0;
            for (int i = 0; i < DEPTH; i++)
                ring_words[i] = '0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(deque_apply(s_cmd, s_data_value, s_position));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no command waiting");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    mismatch_count += field_miss("status", 32'(want.status), 32'(m_status));
                    mismatch_count += field_miss("result_value", want.value, m_result_value);
                    mismatch_count += field_miss("found_position", 32'(want.found),
                                                 32'(m_found_position));
                    mismatch_count += field_miss("entry_count", 32'(want.count),
                                                 32'(m_entry_count));
                end
            end
        end
        fail_count    <= mismatch_count;
        pending_words <= expected_results.size();
    end

endmodule

`default_nettype wire

/* tb/ring_buffer_deque_tb.sv */
`default_nettype none

module ring_buffer_deque_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    // code outside the defined command set
    localparam cmd_t  CMD_UNUSED  = 3'd7;
    localparam word_t WORD_MAX    = 32'sh7fff_ffff;
    localparam word_t WORD_MIN    = 32'sh8000_0000;
    // random words after the 23 directed ones
    localparam int    RANDOM_WORDS = 427;
    // receiver hold-off long enough to back the block up
    localparam int    LONG_HOLD   = 400;
    // quiet cycles allowed before the run is declared hung
    localparam int    QUIET_LIMIT = 4000;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;

    // command channel
    logic    s_valid      = 1'b0;
    logic    s_ready;
    cmd_t    s_cmd        = CMD_PUSH_BACK;
    word_t   s_data_value = '0;
    pos_t    s_position   = '0;

    // result channel
    logic    m_valid;
    logic    m_ready      = 1'b0;
    status_t m_status;
    word_t   m_result_value;
    pos_t    m_found_position;
    cnt_t    m_entry_count;

    int      fail_count;
    int      pending_words;
    int      items_sent    = 0;
    int      results_taken = 0;
    int      quiet_cycles  = 0;
    // no idling on either side while set
    bit      burst_phase   = 1'b0;
    // small set of repeating words so searches hit and duplicates occur
    word_t   word_pool [8];

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ring_buffer_deque u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_data_value     (s_data_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_value   (m_result_value),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    ring_buffer_deque_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_data_value     (s_data_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_value   (m_result_value),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count),
        .fail_count       (fail_count),
        .pending_words    (pending_words)
    );

    // offer one command word, return at the edge that accepts it
    // valid stays high afterward so back-to-back words need no toggle
    task automatic send_word(input cmd_t c, input word_t v, input pos_t p);
        int gap;
        gap = burst_phase ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_cmd        <= c;
        s_data_value <= v;
        s_position   <= p;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result word
    task automatic drain_results();
        s_valid <= 1'b0;
        // let the checker count the last accepted word first
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    // word mix: pool hits, extremes, full random
    function automatic word_t pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return word_pool[$urandom_range(0, 7)];
        if (r == 5) begin
            case ($urandom_range(0, 3))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // command mix biased by phase so the deque swings between empty and full
    function automatic cmd_t pick_cmd(input phase_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return CMD_CLEAR;
        if (r < 3)
            return CMD_UNUSED;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL:
                return (r < 45) ? CMD_PUSH_BACK : (r < 85) ? CMD_PUSH_FRONT :
                       (r < 95) ? CMD_SEARCH : CMD_REMOVE_AT;
            PH_DRAIN:
                return (r < 35) ? CMD_POP_FRONT : (r < 65) ? CMD_POP_BACK :
                       (r < 85) ? CMD_REMOVE_AT : (r < 95) ? CMD_SEARCH : CMD_PUSH_BACK;
            default:
                return (r < 20) ? CMD_PUSH_BACK : (r < 40) ? CMD_PUSH_FRONT :
                       (r < 55) ? CMD_POP_FRONT : (r < 70) ? CMD_POP_BACK :
                       (r < 85) ? CMD_REMOVE_AT : CMD_SEARCH;
        endcase
    endfunction

    // result side: random stall per word, two long hold-offs to back up the block
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = burst_phase ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_taken++;
            if (results_taken == 60 || results_taken == 250) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
        end
    end

    // watchdog: count cycles in which neither channel moves a word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("ring_buffer_deque regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        phase_kind_t kind;
        int          phase_len;
        bit          paused;
        paused = 1'b0;
        for (int i = 0; i < 8; i++)
            word_pool[i] = $urandom;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty deque rejects every read-type command
        send_word(CMD_POP_FRONT, '0, '0);
        send_word(CMD_POP_BACK, '0, '0);
        send_word(CMD_REMOVE_AT, '0, '0);
        send_word(CMD_SEARCH, '0, '0);
        // unused command code
        send_word(CMD_UNUSED, WORD_MAX, 4'hf);
        // extremes at both ends, front push wraps head below zero
        send_word(CMD_PUSH_BACK, WORD_MAX, '0);
        send_word(CMD_PUSH_FRONT, WORD_MIN, '0);
        send_word(CMD_PUSH_BACK, -1, '0);
        send_word(CMD_PUSH_FRONT, '0, '0);
        // search hit and miss
        send_word(CMD_SEARCH, -1, '0);
        send_word(CMD_SEARCH, 32'sd12345, '0);
        // remove-at past the end and exactly at the count
        send_word(CMD_REMOVE_AT, '0, 4'hf);
        send_word(CMD_REMOVE_AT, '0, 4'd4);
        // duplicate word, search must report the last match
        send_word(CMD_PUSH_BACK, -1, '0);
        send_word(CMD_SEARCH, -1, '0);
        // remove from the middle, then both pops
        send_word(CMD_REMOVE_AT, '0, 4'd1);
        send_word(CMD_POP_BACK, '0, '0);
        send_word(CMD_POP_FRONT, '0, '0);
        // clear keeps stale store contents but empties the deque
        send_word(CMD_CLEAR, '0, '0);
        send_word(CMD_POP_FRONT, '0, '0);
        send_word(CMD_SEARCH, WORD_MAX, '0);
        send_word(CMD_PUSH_FRONT, 32'sd5, '0);
        send_word(CMD_POP_BACK, '0, '0);

        // random phases, the first one a fill phase biased toward pushes
        kind      = PH_FILL;
        phase_len = 40;
        while (items_sent < RANDOM_WORDS + 23) begin
            for (int n = 0; n < phase_len && items_sent < RANDOM_WORDS + 23; n++)
                send_word(pick_cmd(kind), pick_value(), pos_t'($urandom_range(0, 15)));
            // sender pause once midway until the block has answered everything
            if (!paused && items_sent >= 250) begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = PH_FILL;
                4, 5, 6:    kind = PH_DRAIN;
                default:    kind = PH_MIXED;
            endcase
            phase_len   = $urandom_range(12, 40);
            burst_phase = ($urandom_range(0, 3) == 0);
        end

        // wait out the tail, then a margin past the longest search
        drain_results();
        repeat (64) @(posedge aclk);
        if (fail_count == 0)
            $display("ring_buffer_deque regression: pass");
        else
            $display("ring_buffer_deque regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
